>>> src/nsw_pkg.sv
// ----------------------------------------------------------------------------
// nsw_pkg
// Shared types and constants for the non-uniform grid stencil weights unit.
// ----------------------------------------------------------------------------
package nsw_pkg;

   // Field formats
   localparam int STEP_WIDTH    = 16;   // unsigned Q4.12 step sizes
   localparam int STEP_FRACTION = 12;
   localparam int WEIGHT_WIDTH  = 48;   // signed Q32.16 weights
   localparam int OUT_FRAC      = 16;
   localparam int COUNT_WIDTH   = 3;
   localparam int LANES         = 5;

   // Internal arithmetic widths
   localparam int NUM_WIDTH      = 42;  // signed numerators
   localparam int DEN_WIDTH      = 58;  // signed denominator
   localparam int DEN_MAG_WIDTH  = 57;  // denominator magnitude
   localparam int DIVIDEND_WIDTH = 80;  // shifted numerator magnitude
   localparam int QR_WIDTH       = DIVIDEND_WIDTH + 1;

   // Scaling shifts for first and second derivatives
   localparam int SHIFT_D1 = STEP_FRACTION + OUT_FRAC;
   localparam int SHIFT_D2 = 2 * STEP_FRACTION + OUT_FRAC;

   // Divider pipeline: quotient bits per stage and stage count
   localparam int DIV_STEP   = 2;
   localparam int DIV_STAGES = DIVIDEND_WIDTH / DIV_STEP;

   typedef enum logic [2:0] {
      OP_D1_C2,
      OP_D1_C4,
      OP_D1_F1,
      OP_D1_F2,
      OP_D1_B1,
      OP_D1_B2,
      OP_D2_C2,
      OP_D2_C4
   } opcode_type;

   typedef logic [DIVIDEND_WIDTH-1:0] dividend_type;
   typedef logic [DEN_MAG_WIDTH-1:0]  rem_type;

   // Side information that travels with an item through the divider
   typedef struct packed {
      logic [LANES-1:0]       neg;
      logic [COUNT_WIDTH-1:0] count;
      logic                   div_err;
   } tag_type;

   // Partial quotient (shifted in at the bottom) and running remainder
   typedef struct packed {
      dividend_type quot;
      rem_type      rem;
   } div_state_type;

endpackage

>>> src/nsw_divider.sv
// ----------------------------------------------------------------------------
// nsw_divider
// Pipelined restoring divider, five lanes sharing one divisor. Each stage
// retires DIV_STEP quotient bits; the dividend register turns into the
// quotient as bits shift out at the top.
// ----------------------------------------------------------------------------
module nsw_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  nsw_pkg::dividend_type in_dividend [nsw_pkg::LANES],
   input  nsw_pkg::rem_type      in_den,
   input  nsw_pkg::tag_type      in_tag,
   output logic                  out_valid,
   output nsw_pkg::dividend_type out_quot [nsw_pkg::LANES],
   output nsw_pkg::rem_type      out_rem [nsw_pkg::LANES],
   output nsw_pkg::rem_type      out_den,
   output nsw_pkg::tag_type      out_tag
);
   import nsw_pkg::*;

   div_state_type st_ff  [DIV_STAGES][LANES];
   rem_type       den_ff [DIV_STAGES];
   tag_type       tag_ff [DIV_STAGES];
   logic          vld_ff [DIV_STAGES];

   // DIV_STEP restoring steps
   function automatic div_state_type div_step(input div_state_type cur, input rem_type d);
      logic [DEN_MAG_WIDTH:0] t;
      div_state_type          st;
      st = cur;
      for (int i = 0; i < DIV_STEP; i++) begin
         t = {st.rem, st.quot[DIVIDEND_WIDTH-1]};
         st.quot = {st.quot[DIVIDEND_WIDTH-2:0], 1'b0};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
            st.quot[0] = 1'b1;
         end
         st.rem = t[DEN_MAG_WIDTH-1:0];
      end
      return st;
   endfunction

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      div_state_type src_st [LANES];
      div_state_type st_in  [LANES];
      rem_type       src_den;
      tag_type       src_tag;
      logic          src_vld;

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               src_st[l].quot = in_dividend[l];
               src_st[l].rem  = '0;
            end
            src_den = in_den;
            src_tag = in_tag;
            src_vld = in_valid;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               src_st[l] = st_ff[s-1][l];
            end
            src_den = den_ff[s-1];
            src_tag = tag_ff[s-1];
            src_vld = vld_ff[s-1];
         end
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            st_in[l] = div_step(src_st[l], src_den);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s]  <= st_in;
            den_ff[s] <= src_den;
            tag_ff[s] <= src_tag;
         end
      end
   end

   // Last stage drives the outputs
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quot[l] = st_ff[DIV_STAGES-1][l].quot;
         out_rem[l]  = st_ff[DIV_STAGES-1][l].rem;
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_den   = den_ff[DIV_STAGES-1];
   assign out_tag   = tag_ff[DIV_STAGES-1];

endmodule

>>> src/nonuniform_stencil_weights_unit.sv
// ----------------------------------------------------------------------------
// nonuniform_stencil_weights_unit
// Finite-difference weights for one point of a non-uniform grid.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries an opcode and four step sizes (unsigned Q4.12); rsp_*
//   returns up to five signed Q32.16 weights, the weight count, a divide
//   error flag (zero denominator, weights forced to zero) and a saturation
//   flag. Both channels are valid/ready; one transfer per item.
//   An item passes 47 register stages: five setup stages (input sums,
//   two multiplier stages, term assembly, sign and scaling), 40 divider
//   stages retiring two quotient bits each, one rounding stage and the
//   output register.
//   Throughput is one item per cycle; the whole pipeline advances together
//   and holds when the output register is full and rsp_ready is low, so a
//   stall loses nothing and req_ready drops only in that case.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module nonuniform_stencil_weights_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [2:0]                                req_opcode,
   input  logic [nsw_pkg::STEP_WIDTH-1:0]            req_step_minus_two,
   input  logic [nsw_pkg::STEP_WIDTH-1:0]            req_step_minus_one,
   input  logic [nsw_pkg::STEP_WIDTH-1:0]            req_step_plus_one,
   input  logic [nsw_pkg::STEP_WIDTH-1:0]            req_step_plus_two,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [nsw_pkg::WEIGHT_WIDTH-1:0]   rsp_weight_a,
   output logic signed [nsw_pkg::WEIGHT_WIDTH-1:0]   rsp_weight_b,
   output logic signed [nsw_pkg::WEIGHT_WIDTH-1:0]   rsp_weight_c,
   output logic signed [nsw_pkg::WEIGHT_WIDTH-1:0]   rsp_weight_d,
   output logic signed [nsw_pkg::WEIGHT_WIDTH-1:0]   rsp_weight_e,
   output logic [nsw_pkg::COUNT_WIDTH-1:0]           rsp_weight_count,
   output logic                                      rsp_divide_error,
   output logic                                      rsp_saturated
);
   import nsw_pkg::*;

   localparam int SW  = STEP_WIDTH;
   localparam int SW1 = STEP_WIDTH + 1;

   logic adv;

   // Pipeline advance: the output register is free or being drained
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: register inputs, pair sums ----------------
   logic           v1_ff;
   opcode_type     op1_ff;
   logic [SW-1:0]  b1_ff, c1_ff, d1_ff;
   logic [SW1-1:0] ab1_ff, cd1_ff, bc1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff <= opcode_type'(req_opcode);
         b1_ff  <= req_step_minus_one;
         c1_ff  <= req_step_plus_one;
         d1_ff  <= req_step_plus_two;
         ab1_ff <= {1'b0, req_step_minus_two} + {1'b0, req_step_minus_one};
         cd1_ff <= {1'b0, req_step_plus_one} + {1'b0, req_step_plus_two};
         bc1_ff <= {1'b0, req_step_minus_one} + {1'b0, req_step_plus_one};
      end
   end

   // ---------------- stage 2: squares and pair products ----------------
   logic                 v2_ff;
   opcode_type           op2_ff;
   logic [SW-1:0]        b2_ff, c2_ff;
   logic [SW1-1:0]       ab2_ff, cd2_ff, bc2_ff;
   logic [2*SW-1:0]      bb2_ff, cc2_ff, dd2_ff, bcp2_ff, cdp2_ff;
   logic [2*SW1-1:0]     abab2_ff, cdcd2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op2_ff   <= op1_ff;
         b2_ff    <= b1_ff;
         c2_ff    <= c1_ff;
         ab2_ff   <= ab1_ff;
         cd2_ff   <= cd1_ff;
         bc2_ff   <= bc1_ff;
         bb2_ff   <= (2*SW)'(b1_ff) * (2*SW)'(b1_ff);
         cc2_ff   <= (2*SW)'(c1_ff) * (2*SW)'(c1_ff);
         dd2_ff   <= (2*SW)'(d1_ff) * (2*SW)'(d1_ff);
         bcp2_ff  <= (2*SW)'(b1_ff) * (2*SW)'(c1_ff);
         cdp2_ff  <= (2*SW)'(c1_ff) * (2*SW)'(d1_ff);
         abab2_ff <= (2*SW1)'(ab1_ff) * (2*SW1)'(ab1_ff);
         cdcd2_ff <= (2*SW1)'(cd1_ff) * (2*SW1)'(cd1_ff);
      end
   end

   // ---------------- stage 3: cubic denominator terms ----------------
   logic               v3_ff;
   opcode_type         op3_ff;
   logic [SW-1:0]      b3_ff, c3_ff;
   logic [SW1-1:0]     ab3_ff, cd3_ff, bc3_ff;
   logic [2*SW-1:0]    bb3_ff, cc3_ff, dd3_ff, cdp3_ff;
   logic [2*SW1-1:0]   abab3_ff, cdcd3_ff;
   logic [3*SW1-1:0]   ab2cd3_ff, abcd2_3_ff;
   logic [3*SW-1:0]    cbb3_ff, ccb3_ff;
   logic [3*SW:0]      bcbc3_ff, cdcd_p3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op3_ff     <= op2_ff;
         b3_ff      <= b2_ff;
         c3_ff      <= c2_ff;
         ab3_ff     <= ab2_ff;
         cd3_ff     <= cd2_ff;
         bc3_ff     <= bc2_ff;
         bb3_ff     <= bb2_ff;
         cc3_ff     <= cc2_ff;
         dd3_ff     <= dd2_ff;
         cdp3_ff    <= cdp2_ff;
         abab3_ff   <= abab2_ff;
         cdcd3_ff   <= cdcd2_ff;
         ab2cd3_ff  <= (3*SW1)'(abab2_ff) * (3*SW1)'(cd2_ff);
         abcd2_3_ff <= (3*SW1)'(ab2_ff) * (3*SW1)'(cdcd2_ff);
         cbb3_ff    <= (3*SW)'(c2_ff) * (3*SW)'(bb2_ff);
         ccb3_ff    <= (3*SW)'(cc2_ff) * (3*SW)'(b2_ff);
         bcbc3_ff   <= (3*SW+1)'(bcp2_ff) * (3*SW+1)'(bc2_ff);
         cdcd_p3_ff <= (3*SW+1)'(cdp2_ff) * (3*SW+1)'(cd2_ff);
      end
   end

   // ---------------- stage 4: assemble numerators and denominator ----------------
   logic                        v4_ff;
   logic                        d2_4_ff;
   logic [COUNT_WIDTH-1:0]      cnt4_ff;
   logic signed [DEN_WIDTH-1:0] den4_ff;
   logic signed [NUM_WIDTH-1:0] num4_ff [LANES];

   logic                        d2_4_in;
   logic [COUNT_WIDTH-1:0]      cnt4_in;
   logic signed [DEN_WIDTH-1:0] den4_in;
   logic signed [NUM_WIDTH-1:0] num4_in [LANES];

   always_comb begin
      logic signed [DEN_WIDTH-1:0] t_ab2cd, t_abcd2, t_cbb, t_ccb, t_c4den;
      logic signed [NUM_WIDTH-1:0] s_bb, s_cc, s_dd, s_cdp, s_abab, s_cdcd;
      logic signed [NUM_WIDTH-1:0] s_ab, s_cd, s_b, s_c, s_bc, s_one, s_tmp;

      t_ab2cd = signed'(DEN_WIDTH'(ab2cd3_ff));
      t_abcd2 = signed'(DEN_WIDTH'(abcd2_3_ff));
      t_cbb   = signed'(DEN_WIDTH'(cbb3_ff));
      t_ccb   = signed'(DEN_WIDTH'(ccb3_ff));
      t_c4den = t_ab2cd - (t_cbb <<< 5) - (t_ccb <<< 5) + t_abcd2;

      s_bb   = signed'(NUM_WIDTH'(bb3_ff));
      s_cc   = signed'(NUM_WIDTH'(cc3_ff));
      s_dd   = signed'(NUM_WIDTH'(dd3_ff));
      s_cdp  = signed'(NUM_WIDTH'(cdp3_ff));
      s_abab = signed'(NUM_WIDTH'(abab3_ff));
      s_cdcd = signed'(NUM_WIDTH'(cdcd3_ff));
      s_ab   = signed'(NUM_WIDTH'(ab3_ff));
      s_cd   = signed'(NUM_WIDTH'(cd3_ff));
      s_b    = signed'(NUM_WIDTH'(b3_ff));
      s_c    = signed'(NUM_WIDTH'(c3_ff));
      s_bc   = signed'(NUM_WIDTH'(bc3_ff));
      s_one  = signed'(NUM_WIDTH'(1));
      s_tmp  = '0;

      for (int l = 0; l < LANES; l++) begin
         num4_in[l] = '0;
      end
      d2_4_in = 1'b0;

      unique case (op3_ff)
         OP_D1_C2: begin
            den4_in    = signed'(DEN_WIDTH'(bcbc3_ff));
            num4_in[0] = -s_cc;
            num4_in[1] = s_cc - s_bb;
            num4_in[2] = s_bb;
            cnt4_in    = COUNT_WIDTH'(3);
         end
         OP_D1_C4: begin
            den4_in    = t_c4den;
            num4_in[0] = -s_cdcd;
            num4_in[1] = s_cc <<< 5;
            num4_in[2] = -(s_abab - (s_bb <<< 5) + (s_cc <<< 5) - s_cdcd);
            num4_in[3] = -(s_bb <<< 5);
            num4_in[4] = s_abab;
            cnt4_in    = COUNT_WIDTH'(5);
         end
         OP_D1_F1, OP_D1_B1: begin
            den4_in    = signed'(DEN_WIDTH'(c3_ff));
            num4_in[0] = -s_one;
            num4_in[1] = s_one;
            cnt4_in    = COUNT_WIDTH'(2);
         end
         OP_D1_F2, OP_D1_B2: begin
            den4_in    = -signed'(DEN_WIDTH'(cdcd_p3_ff));
            num4_in[0] = s_dd + (s_cdp <<< 1);
            num4_in[1] = -s_cdcd;
            num4_in[2] = s_cc;
            cnt4_in    = COUNT_WIDTH'(3);
         end
         OP_D2_C2: begin
            den4_in    = signed'(DEN_WIDTH'(bcbc3_ff));
            num4_in[0] = s_c <<< 1;
            num4_in[1] = -(s_bc <<< 1);
            num4_in[2] = s_b <<< 1;
            cnt4_in    = COUNT_WIDTH'(3);
            d2_4_in    = 1'b1;
         end
         OP_D2_C4: begin
            den4_in    = -t_c4den;
            num4_in[0] = -(s_cd <<< 1);
            num4_in[1] = s_c <<< 6;
            num4_in[2] = -((-s_ab + (s_b <<< 5) + (s_c <<< 5) - s_cd) <<< 1);
            num4_in[3] = s_b <<< 6;
            num4_in[4] = -(s_ab <<< 1);
            cnt4_in    = COUNT_WIDTH'(5);
            d2_4_in    = 1'b1;
         end
         default: begin
            den4_in = '0;
            cnt4_in = '0;
         end
      endcase

      // Backward stencils: forward weights reversed and negated
      if (op3_ff == OP_D1_B1) begin
         s_tmp      = num4_in[0];
         num4_in[0] = -num4_in[1];
         num4_in[1] = -s_tmp;
      end else if (op3_ff == OP_D1_B2) begin
         s_tmp      = num4_in[0];
         num4_in[0] = -num4_in[2];
         num4_in[1] = -num4_in[1];
         num4_in[2] = -s_tmp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_4_ff <= d2_4_in;
         cnt4_ff <= cnt4_in;
         den4_ff <= den4_in;
         num4_ff <= num4_in;
      end
   end

   // ---------------- stage 5: signs, magnitudes, scaling ----------------
   logic         v5_ff;
   tag_type      tag5_ff;
   rem_type      den5_ff;
   dividend_type div5_ff [LANES];

   tag_type      tag5_in;
   rem_type      den5_in;
   dividend_type div5_in [LANES];

   always_comb begin
      logic                   den_neg;
      logic [NUM_WIDTH-2:0]   nmag;
      den_neg         = den4_ff < 0;
      tag5_in.div_err = den4_ff == '0;
      tag5_in.count   = cnt4_ff;
      den5_in = tag5_in.div_err ? rem_type'(1)
                : DEN_MAG_WIDTH'(den_neg ? -den4_ff : den4_ff);
      for (int l = 0; l < LANES; l++) begin
         nmag = (NUM_WIDTH-1)'(num4_ff[l] < 0 ? -num4_ff[l] : num4_ff[l]);
         tag5_in.neg[l] = (num4_ff[l] < 0) ^ den_neg;
         if (tag5_in.div_err) begin
            div5_in[l] = '0;
         end else if (d2_4_ff) begin
            div5_in[l] = DIVIDEND_WIDTH'(nmag) << SHIFT_D2;
         end else begin
            div5_in[l] = DIVIDEND_WIDTH'(nmag) << SHIFT_D1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag5_ff <= tag5_in;
         den5_ff <= den5_in;
         div5_ff <= div5_in;
      end
   end

   // ---------------- divider ----------------
   logic         vq;
   dividend_type quot [LANES];
   rem_type      rem  [LANES];
   rem_type      denq;
   tag_type      tagq;

   nsw_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (v5_ff),
      .in_dividend (div5_ff),
      .in_den      (den5_ff),
      .in_tag      (tag5_ff),
      .out_valid   (vq),
      .out_quot    (quot),
      .out_rem     (rem),
      .out_den     (denq),
      .out_tag     (tagq)
   );

   // ---------------- round stage: nearest, ties away from zero ----------------
   logic                vr_ff;
   tag_type             tagr_ff;
   logic [QR_WIDTH-1:0] qr_ff [LANES];
   logic [QR_WIDTH-1:0] qr_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         qr_in[l] = {1'b0, quot[l]}
                  + QR_WIDTH'({rem[l], 1'b0} >= {1'b0, denq});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= vq;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tagr_ff <= tagq;
         qr_ff   <= qr_in;
      end
   end

   // ---------------- output stage: saturate, apply sign ----------------
   localparam logic [WEIGHT_WIDTH-1:0] POS_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
   localparam logic [WEIGHT_WIDTH-1:0] NEG_MAG = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
   localparam logic [QR_WIDTH-1:0]     NEG_LIM = QR_WIDTH'(NEG_MAG);

   logic                          rsp_valid_ff;
   logic [WEIGHT_WIDTH-1:0]       w_ff  [LANES];
   logic [COUNT_WIDTH-1:0]        cnt_ff;
   logic                          err_ff;
   logic                          sat_ff;
   logic [WEIGHT_WIDTH-1:0]       w_in  [LANES];
   logic                          sat_in;

   always_comb begin
      logic                    over;
      logic                    clip;
      logic [WEIGHT_WIDTH-1:0] mag;
      sat_in = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         over = |qr_ff[l][QR_WIDTH-1:WEIGHT_WIDTH-1];
         clip = tagr_ff.neg[l] ? (over && (qr_ff[l] != NEG_LIM)) : over;
         if (clip) begin
            mag = tagr_ff.neg[l] ? NEG_MAG : POS_MAX;
         end else begin
            mag = qr_ff[l][WEIGHT_WIDTH-1:0];
         end
         if (tagr_ff.div_err) begin
            w_in[l] = '0;
         end else begin
            w_in[l] = tagr_ff.neg[l] ? -mag : mag;
            sat_in  = sat_in | clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff   <= w_in;
         cnt_ff <= tagr_ff.count;
         err_ff <= tagr_ff.div_err;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weight_a     = signed'(w_ff[0]);
   assign rsp_weight_b     = signed'(w_ff[1]);
   assign rsp_weight_c     = signed'(w_ff[2]);
   assign rsp_weight_d     = signed'(w_ff[3]);
   assign rsp_weight_e     = signed'(w_ff[4]);
   assign rsp_weight_count = cnt_ff;
   assign rsp_divide_error = err_ff;
   assign rsp_saturated    = sat_ff;

   // ---------------- assertions ----------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_weight_a == '0 && rsp_weight_b == '0 &&
         rsp_weight_c == '0 && rsp_weight_d == '0 && rsp_weight_e == '0 && !rsp_saturated)
      else $error("divide error with nonzero weights or saturation");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight_count == 3'd2 || rsp_weight_count == 3'd3 ||
                    rsp_weight_count == 3'd5)
      else $error("illegal weight count");

   a_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_weight_count != 3'd5 |->
         rsp_weight_d == '0 && rsp_weight_e == '0 &&
         (rsp_weight_count != 3'd2 || rsp_weight_c == '0))
      else $error("unused weight slot not zero");

endmodule
